@@ rtl/ouis_pkg.sv @@
// ouis_pkg: request codes, result record and controller command bundle
// for the ordered unique id set; no dependencies
`default_nettype none

package ouis_pkg;

  // request kinds carried in req_type
  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_TOGGLE   = 3'd2,
    REQ_CONTAINS = 3'd3,
    REQ_READ_AT  = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic match;
    logic apply;
  } cmd_t;

  // one result record
  typedef struct packed {
    logic        ok;
    logic [15:0] read_id;
    logic        is_member;
    logic [5:0]  entry_count;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ouis_req_if.sv @@
// ouis_req_if: valid/ready request channel of the ordered unique id set
// no dependencies
`default_nettype none

interface ouis_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] item_id;
  logic [4:0]  position;

  modport source (output valid, output req_type, output item_id, output position,
                  input ready);
  modport sink   (input valid, input req_type, input item_id, input position,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/ouis_rsp_if.sv @@
// ouis_rsp_if: valid/ready result channel of the ordered unique id set
// no dependencies
`default_nettype none

interface ouis_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] read_id;
  logic        is_member;
  logic [5:0]  entry_count;

  modport source (output valid, output ok, output read_id, output is_member,
                  output entry_count, input ready);
  modport sink   (input valid, input ok, input read_id, input is_member,
                  input entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/ordered_unique_id_set.sv @@
// ordered_unique_id_set: top level, insertion ordered set of nonzero ids
// depends on ouis_pkg, ouis_req_if, ouis_rsp_if, ouis_ctrl, ouis_datapath
//
//   port  dir  moves       payload
//   req   in   request     req_type[2:0], item_id[15:0], position[4:0]
//   rsp   out  result      ok, read_id[15:0], is_member, entry_count[5:0]
//
// the accepting edge captures the request; one compare pass over all slot
// cells and one apply step follow, and the apply step raises the result.
// synchronous reset empties the set at once; no clearing pass is needed.
// a held result stalls the block: no new request is taken until it goes.
`default_nettype none

module ordered_unique_id_set #(
  parameter int CAPACITY = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  ouis_req_if.sink   req,
  ouis_rsp_if.source rsp
);

  ouis_pkg::cmd_t    cmd;
  ouis_pkg::result_t result;

  ouis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  ouis_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_type (req.req_type),
    .item_id  (req.item_id),
    .position (req.position),
    .result   (result)
  );

  // result payload
  assign rsp.ok          = result.ok;
  assign rsp.read_id     = result.read_id;
  assign rsp.is_member   = result.is_member;
  assign rsp.entry_count = result.entry_count;

endmodule

`default_nettype wire

@@ rtl/ouis_ctrl.sv @@
// ouis_ctrl: request sequencer of the ordered unique id set
// depends on ouis_pkg
`default_nettype none

module ouis_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ouis_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_DONE
  } state_t;

  state_t state;

  // commands to the datapath
  assign cmd.load  = in_valid && in_ready;
  assign cmd.match = (state == ST_MATCH);
  assign cmd.apply = (state == ST_APPLY);

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_MATCH;
            in_ready <= 1'b0;
          end
        end
        ST_MATCH: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          state     <= ST_DONE;
          out_valid <= 1'b1;
        end
        ST_DONE: begin
          if (out_ready) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
          in_ready  <= 1'b1;
        end
      endcase
    end
  end

  // a result appears only right after the apply step
  a_valid_after_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("result raised outside apply");

  // never open for a request while a result is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("ready and valid overlap");

  // an accepted request always goes to the match step
  a_load_match: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.match)
    else $error("accepted request skipped match");

endmodule

`default_nettype wire

@@ rtl/ouis_datapath.sv @@
// ouis_datapath: id slot cells, compare row, count and result register
// depends on ouis_pkg
`default_nettype none

module ouis_datapath #(
  parameter int CAPACITY = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ouis_pkg::cmd_t    cmd,
  input  wire logic [2:0]        req_type,
  input  wire logic [15:0]       item_id,
  input  wire logic [4:0]        position,
  output ouis_pkg::result_t      result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [15:0]         slots [CAPACITY];
  logic [CW-1:0]       count;
  ouis_pkg::req_kind_t kind;
  logic [15:0]         id;
  logic [4:0]          pos;
  logic                hit;
  logic [CW-1:0]       hit_idx;
  logic                ok;
  logic [15:0]         rd;
  logic                member;

  logic [CAPACITY-1:0] hit_vec;
  logic [CW-1:0]       idx_enc;
  logic [15:0]         rd_mux;
  logic                room;
  logic                pos_in;
  logic                do_add;
  logic                do_rem;
  logic                do_clr;
  logic                ok_next;
  logic                member_next;
  logic [15:0]         rd_next;
  logic [CW+5:0]       count_ext;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= ouis_pkg::req_kind_t'(req_type);
      id   <= item_id;
      pos  <= position;
    end
  end

  // compare row over live entries, ids are unique so at most one hit
  always_comb begin
    idx_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = (slots[i] == id) && (CW'(i) < count) && (id != 16'd0);
      if (hit_vec[i]) idx_enc = idx_enc | CW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit     <= |hit_vec;
      hit_idx <= idx_enc;
    end
  end

  // read-at select
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (int'(pos) == i) rd_mux = slots[i];
    end
  end

  assign room   = count < CW'(CAPACITY);
  assign pos_in = (CW + 5)'(pos) < (CW + 5)'(count);

  // per request decision
  always_comb begin
    do_add      = 1'b0;
    do_rem      = 1'b0;
    do_clr      = 1'b0;
    ok_next     = 1'b0;
    member_next = hit;
    rd_next     = '0;
    case (kind)
      ouis_pkg::REQ_ADD: begin
        do_add      = (id != 16'd0) && !hit && room;
        ok_next     = do_add;
        member_next = hit || do_add;
      end
      ouis_pkg::REQ_REMOVE: begin
        do_rem      = hit;
        ok_next     = hit;
        member_next = 1'b0;
      end
      ouis_pkg::REQ_TOGGLE: begin
        do_rem      = hit;
        do_add      = (id != 16'd0) && !hit && room;
        ok_next     = hit || do_add;
        member_next = do_add;
      end
      ouis_pkg::REQ_CONTAINS: begin
        ok_next = hit;
      end
      ouis_pkg::REQ_READ_AT: begin
        ok_next = pos_in;
        rd_next = pos_in ? rd_mux : 16'd0;
      end
      ouis_pkg::REQ_CLEAR: begin
        do_clr      = 1'b1;
        ok_next     = 1'b1;
        member_next = 1'b0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // slot cells: append at the fill point, close the gap on remove
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          if (do_add && (CW'(g) == count)) begin
            slots[g] <= id;
          end else if (do_rem && (CW'(g) >= hit_idx)) begin
            slots[g] <= 16'd0;
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          if (do_add && (CW'(g) == count)) begin
            slots[g] <= id;
          end else if (do_rem && (CW'(g) >= hit_idx)) begin
            slots[g] <= slots[g+1];
          end
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      if (do_clr) begin
        count <= '0;
      end else if (do_add) begin
        count <= count + CW'(1);
      end else if (do_rem) begin
        count <= count - CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      ok     <= ok_next;
      rd     <= rd_next;
      member <= member_next;
    end
  end

  assign count_ext          = (CW + 6)'(count);
  assign result.ok          = ok;
  assign result.read_id     = rd;
  assign result.is_member   = member;
  assign result.entry_count = count_ext[5:0];

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // count moves only in the apply step
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.apply |=> $stable(count))
    else $error("fill count changed outside apply");

  // clear empties the set
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && (kind == ouis_pkg::REQ_CLEAR) |=> count == '0)
    else $error("clear left entries");

endmodule

`default_nettype wire
